[rtl/sfspa_pkg.sv]
// ----------------------------------------------------------------------------
// sfspa_pkg
// Shared types, constants and register indexes for the front-sector
// proximity alert block.
// ----------------------------------------------------------------------------
package sfspa_pkg;

    localparam int MAX_SCAN_POINTS_DEF = 8192;
    localparam int QUEUE_DEPTH         = 2;

    localparam int SCAN_W  = 14;
    localparam int RANGE_W = 16;
    localparam int SCORE_W = 16;
    localparam int ALERT_W = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int SCORE_FRAC = 15;
    localparam int DIV_CNT_W  = $clog2(SCORE_FRAC);

    localparam logic [SCAN_W-1:0]  SCAN_POINTS_RST = SCAN_W'(720);
    localparam logic [RANGE_W-1:0] RANGE_MIN_RST   = RANGE_W'(20);
    localparam logic [RANGE_W-1:0] RANGE_MAX_RST   = RANGE_W'(30000);
    localparam logic [RANGE_W-1:0] SAFETY_RST      = RANGE_W'(500);
    localparam logic               ENABLE_RST      = 1'b1;

    localparam logic [RANGE_W-1:0] RANGE_NONE  = {RANGE_W{1'b1}};
    localparam logic [SCORE_W-1:0] SCORE_CLEAR = SCORE_W'(1) << SCORE_FRAC;

    localparam logic [ALERT_W-1:0] ALERT_NONE   = 2'd0;
    localparam logic [ALERT_W-1:0] ALERT_MEDIUM = 2'd1;
    localparam logic [ALERT_W-1:0] ALERT_HIGH   = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCAN_POINTS = 3'd0,
        REG_RANGE_MIN   = 3'd1,
        REG_RANGE_MAX   = 3'd2,
        REG_SAFETY      = 3'd3,
        REG_ENABLE      = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic [SCAN_W-1:0]  scan_points;
        logic [RANGE_W-1:0] range_min_mm;
        logic [RANGE_W-1:0] range_max_mm;
        logic [RANGE_W-1:0] safety_distance_mm;
        logic               monitor_enable;
    } cfg_t;

    typedef struct packed {
        logic [RANGE_W-1:0] min_mm;
        logic [RANGE_W-1:0] thr_mm;
    } scan_rec_t;

    typedef enum logic [1:0] {
        B_IDLE = 2'd0,
        B_DIV  = 2'd1,
        B_HOLD = 2'd2
    } back_state_t;

endpackage

[rtl/sfspa_front.sv]
// ----------------------------------------------------------------------------
// sfspa_front
// Counts samples within a scan, gates the front sector and range window,
// tracks the running minimum and hands one record per scan to the queue while monitoring is enabled.
// ----------------------------------------------------------------------------
module sfspa_front #(
    parameter int MAX_SCAN_POINTS = sfspa_pkg::MAX_SCAN_POINTS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  sfspa_pkg::cfg_t                  cfg,
    input  logic                             push,
    output logic                             full,
    input  logic [sfspa_pkg::RANGE_W-1:0]    range_mm,
    output logic                             rec_push,
    output sfspa_pkg::scan_rec_t             rec_data,
    input  logic                             rec_full
);

    localparam int IDX_W = $clog2(MAX_SCAN_POINTS);
    localparam int LEN_W = $clog2(MAX_SCAN_POINTS + 1);
    localparam int CW    = (LEN_W > sfspa_pkg::SCAN_W) ? LEN_W : sfspa_pkg::SCAN_W;

    logic [IDX_W-1:0]              idx_reg, idx_next;
    logic [sfspa_pkg::RANGE_W-1:0] min_reg, min_next;

    logic [CW-1:0]    sp_ext;
    logic [CW-1:0]    n_clamp;
    logic [LEN_W-1:0] n_len;
    logic [LEN_W-1:0] lo_idx;
    logic [LEN_W+1:0] three_n;
    logic [LEN_W-1:0] hi_idx;
    logic [LEN_W-1:0] idx_ext;
    logic             last;
    logic             in_sector;
    logic             qualify;
    logic             accept;
    logic [sfspa_pkg::RANGE_W-1:0] min_upd;

    always_comb
    begin
        sp_ext = CW'(cfg.scan_points);
        if (sp_ext < CW'(4))
        begin
            n_clamp = CW'(4);
        end
        else if (sp_ext > CW'(MAX_SCAN_POINTS))
        begin
            n_clamp = CW'(MAX_SCAN_POINTS);
        end
        else
        begin
            n_clamp = sp_ext;
        end
        n_len   = n_clamp[LEN_W-1:0];
        lo_idx  = n_len >> 2;
        three_n = {2'b00, n_len} + {1'b0, n_len, 1'b0};
        hi_idx  = three_n[LEN_W+1:2];
        idx_ext = LEN_W'(idx_reg);
        last    = idx_ext >= (n_len - LEN_W'(1));
    end

    always_comb
    begin
        in_sector = (idx_ext >= lo_idx) && (idx_ext < hi_idx);
        qualify   = in_sector && (range_mm > cfg.range_min_mm) &&
                    (range_mm < cfg.range_max_mm) && (range_mm < min_reg);
        min_upd   = qualify ? range_mm : min_reg;
    end

    // only the closing sample of a scan needs room downstream
    assign full   = rec_full && last;
    assign accept = push && !full;

    always_comb
    begin
        idx_next = idx_reg;
        min_next = min_reg;
        rec_push = 1'b0;
        rec_data.min_mm = min_upd;
        rec_data.thr_mm = cfg.safety_distance_mm;
        if (accept)
        begin
            if (last)
            begin
                idx_next = '0;
                min_next = sfspa_pkg::RANGE_NONE;
                rec_push = cfg.monitor_enable;
            end
            else
            begin
                idx_next = idx_reg + IDX_W'(1);
                min_next = min_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            min_reg <= sfspa_pkg::RANGE_NONE;
        end
        else
        begin
            idx_reg <= idx_next;
            min_reg <= min_next;
        end
    end

`ifndef SYNTHESIS
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        rec_push |-> !rec_full)
        else $error("record transfer while queue full");
    a_idx_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last) |=> (idx_reg == '0 && min_reg == sfspa_pkg::RANGE_NONE))
        else $error("scan state not restarted");
    a_min_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !last) |=> (min_reg <= $past(min_reg)))
        else $error("running minimum grew within a scan");
`endif

endmodule

[rtl/sfspa_queue.sv]
// ----------------------------------------------------------------------------
// sfspa_queue
// Short register queue of per-scan records between front and back.
// ----------------------------------------------------------------------------
module sfspa_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  sfspa_pkg::scan_rec_t wr_data,
    output logic                 q_full,
    input  logic                 rd_en,
    output sfspa_pkg::scan_rec_t rd_data,
    output logic                 q_empty
);

    localparam int D     = sfspa_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (D > 1) ? $clog2(D) : 1;
    localparam int CNT_W = $clog2(D + 1);

    sfspa_pkg::scan_rec_t entry_reg [D];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr;
    logic             do_rd;

    assign q_full  = cnt_reg == CNT_W'(D);
    assign q_empty = cnt_reg == '0;
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(D - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(D - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(D))
        else $error("queue count overflow");
    a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> (cnt_reg == $past(cnt_reg) + CNT_W'(1)))
        else $error("queue count lost a write");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0 || cnt_reg == CNT_W'(D)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");
`endif

endmodule

[rtl/sfspa_back.sv]
// ----------------------------------------------------------------------------
// sfspa_back
// Takes one scan record, grades the alert level, works out the Q1.15 score
// (bit-serial restoring divider below threshold) and holds the result until popped.
// ----------------------------------------------------------------------------
module sfspa_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sfspa_pkg::scan_rec_t          rec_data,
    input  logic                          rec_empty,
    output logic                          rec_pop,
    output logic                          empty,
    input  logic                          pop,
    output logic [sfspa_pkg::RANGE_W-1:0] min_range_mm,
    output logic [sfspa_pkg::SCORE_W-1:0] proximity_score,
    output logic [sfspa_pkg::ALERT_W-1:0] alert_level
);

    localparam int RW = sfspa_pkg::RANGE_W;
    localparam int QW = sfspa_pkg::SCORE_FRAC;
    localparam int CNTW = sfspa_pkg::DIV_CNT_W;

    sfspa_pkg::back_state_t state_reg, state_next;

    logic [RW-1:0]                   min_reg, min_next;
    logic [RW-1:0]                   thr_reg, thr_next;
    logic [RW-1:0]                   rem_reg, rem_next;
    logic [QW-1:0]                   quo_reg, quo_next;
    logic [CNTW-1:0]                 cnt_reg, cnt_next;
    logic [sfspa_pkg::SCORE_W-1:0]   score_reg, score_next;
    logic [sfspa_pkg::ALERT_W-1:0]   alert_reg, alert_next;

    logic [RW:0] rem_shift;
    logic [RW:0] rem_sub;
    logic        q_bit;
    logic [QW-1:0] quo_shift;

    always_comb
    begin
        rem_shift = {rem_reg, 1'b0};
        rem_sub   = rem_shift - {1'b0, thr_reg};
        q_bit     = rem_shift >= {1'b0, thr_reg};
        quo_shift = {quo_reg[QW-2:0], q_bit};
    end

    always_comb
    begin
        state_next = state_reg;
        min_next   = min_reg;
        thr_next   = thr_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        score_next = score_reg;
        alert_next = alert_reg;
        rec_pop    = 1'b0;
        case (state_reg)
            sfspa_pkg::B_IDLE:
            begin
                if (!rec_empty)
                begin
                    rec_pop  = 1'b1;
                    min_next = rec_data.min_mm;
                    thr_next = rec_data.thr_mm;
                    rem_next = rec_data.min_mm;
                    quo_next = '0;
                    cnt_next = '0;
                    if (rec_data.min_mm < rec_data.thr_mm)
                    begin
                        alert_next = ({rec_data.min_mm, 1'b0} < {1'b0, rec_data.thr_mm}) ?
                                     sfspa_pkg::ALERT_HIGH : sfspa_pkg::ALERT_MEDIUM;
                        state_next = sfspa_pkg::B_DIV;
                    end
                    else
                    begin
                        alert_next = sfspa_pkg::ALERT_NONE;
                        score_next = sfspa_pkg::SCORE_CLEAR;
                        state_next = sfspa_pkg::B_HOLD;
                    end
                end
            end
            sfspa_pkg::B_DIV:
            begin
                rem_next = q_bit ? rem_sub[RW-1:0] : rem_shift[RW-1:0];
                quo_next = quo_shift;
                cnt_next = cnt_reg + CNTW'(1);
                if (cnt_reg == CNTW'(QW - 1))
                begin
                    score_next = sfspa_pkg::SCORE_W'(quo_shift);
                    state_next = sfspa_pkg::B_HOLD;
                end
            end
            sfspa_pkg::B_HOLD:
            begin
                if (pop)
                begin
                    state_next = sfspa_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = sfspa_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sfspa_pkg::B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        min_reg   <= min_next;
        thr_reg   <= thr_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        cnt_reg   <= cnt_next;
        score_reg <= score_next;
        alert_reg <= alert_next;
    end

    assign empty           = state_reg != sfspa_pkg::B_HOLD;
    assign min_range_mm    = min_reg;
    assign proximity_score = score_reg;
    assign alert_level     = alert_reg;

`ifndef SYNTHESIS
    a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sfspa_pkg::B_DIV) |-> (rem_reg < thr_reg))
        else $error("divider remainder out of range");
    a_score_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (proximity_score <= sfspa_pkg::SCORE_CLEAR))
        else $error("score above one");
    a_alert_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && alert_level == sfspa_pkg::ALERT_NONE) |->
        (proximity_score == sfspa_pkg::SCORE_CLEAR))
        else $error("clear alert with reduced score");
    a_pop_release: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop) |=> (state_reg == sfspa_pkg::B_IDLE))
        else $error("result not released after transfer");
`endif

endmodule

[rtl/scan_front_sector_proximity_alert.sv]
// ----------------------------------------------------------------------------
// scan_front_sector_proximity_alert
// Front-sector minimum range monitor with Q1.15 proximity score and alert.
// ----------------------------------------------------------------------------
// samples: one transfer per cycle; only the closing sample of a scan can stall
// result: held in the back end; set directly when clear, else by the 15-step
//   bit-serial divider; one divider pass per scan sets the scan rate floor
// two scan records queue between sample front and divider back
// reset: config registers return to their defaults, scan restarts at index zero
// ----------------------------------------------------------------------------
module scan_front_sector_proximity_alert #(
    parameter int MAX_SCAN_POINTS = sfspa_pkg::MAX_SCAN_POINTS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [sfspa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sfspa_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                             push,
    output logic                             full,
    input  logic [sfspa_pkg::RANGE_W-1:0]    range_mm,
    output logic                             empty,
    input  logic                             pop,
    output logic [sfspa_pkg::RANGE_W-1:0]    min_range_mm,
    output logic [sfspa_pkg::SCORE_W-1:0]    proximity_score,
    output logic [sfspa_pkg::ALERT_W-1:0]    alert_level
);

    sfspa_pkg::cfg_t      cfg_reg;
    sfspa_pkg::scan_rec_t wr_rec;
    sfspa_pkg::scan_rec_t rd_rec;
    logic                 wr_en;
    logic                 q_full;
    logic                 rd_en;
    logic                 q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scan_points        <= sfspa_pkg::SCAN_POINTS_RST;
            cfg_reg.range_min_mm       <= sfspa_pkg::RANGE_MIN_RST;
            cfg_reg.range_max_mm       <= sfspa_pkg::RANGE_MAX_RST;
            cfg_reg.safety_distance_mm <= sfspa_pkg::SAFETY_RST;
            cfg_reg.monitor_enable     <= sfspa_pkg::ENABLE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sfspa_pkg::REG_SCAN_POINTS:
                    cfg_reg.scan_points <= cfg_data[sfspa_pkg::SCAN_W-1:0];
                sfspa_pkg::REG_RANGE_MIN:
                    cfg_reg.range_min_mm <= cfg_data[sfspa_pkg::RANGE_W-1:0];
                sfspa_pkg::REG_RANGE_MAX:
                    cfg_reg.range_max_mm <= cfg_data[sfspa_pkg::RANGE_W-1:0];
                sfspa_pkg::REG_SAFETY:
                    cfg_reg.safety_distance_mm <= cfg_data[sfspa_pkg::RANGE_W-1:0];
                sfspa_pkg::REG_ENABLE:
                    cfg_reg.monitor_enable <= cfg_data[0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    sfspa_front #(
        .MAX_SCAN_POINTS(MAX_SCAN_POINTS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .push     (push),
        .full     (full),
        .range_mm (range_mm),
        .rec_push (wr_en),
        .rec_data (wr_rec),
        .rec_full (q_full)
    );

    sfspa_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_data (wr_rec),
        .q_full  (q_full),
        .rd_en   (rd_en),
        .rd_data (rd_rec),
        .q_empty (q_empty)
    );

    sfspa_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .rec_data        (rd_rec),
        .rec_empty       (q_empty),
        .rec_pop         (rd_en),
        .empty           (empty),
        .pop             (pop),
        .min_range_mm    (min_range_mm),
        .proximity_score (proximity_score),
        .alert_level     (alert_level)
    );

endmodule
